>>> design/eucjp_pkg.sv
// Shared types, constants and escape tables for the EUC-JP to Compound Text converter.
`default_nettype none
package eucjp_pkg;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BYTE_NUL  = 8'h00;
    localparam logic [7:0] BYTE_SS2  = 8'h8e;
    localparam logic [7:0] BYTE_SS3  = 8'h8f;
    localparam logic [7:0] ASCII_MAX = 8'h7f;

    typedef enum logic [1:0] {
        SET_NONE   = 2'd0,
        SET_JX0201 = 2'd1,
        SET_JX0208 = 2'd2,
        SET_JX0212 = 2'd3
    } right_set_t;

    // One queued command: an optional escape sequence, then an optional byte.
    typedef struct packed {
        right_set_t  esc_sel;
        logic        has_byte;
        logic [7:0]  data;
        logic        eot;
        logic        trunc;
    } cmd_t;

    function automatic logic [2:0] esc_len(input right_set_t sel);
        logic [2:0] len;
        unique case (sel)
            SET_NONE:   len = 3'd0;
            SET_JX0201: len = 3'd3;
            SET_JX0208: len = 3'd4;
            SET_JX0212: len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] esc_byte(input right_set_t sel, input logic [1:0] idx);
        logic [7:0] b;
        b = 8'h1b;
        unique case (idx)
            2'd0: b = 8'h1b;
            2'd1: b = (sel == SET_JX0201) ? 8'h29 : 8'h24;
            2'd2: b = (sel == SET_JX0201) ? 8'h49 : 8'h29;
            2'd3: b = (sel == SET_JX0212) ? 8'h44 : 8'h42;
            default: b = 8'h1b;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

>>> design/eucjp_in_if.sv
// Input channel interface: one EUC-JP byte per item.
`default_nettype none
interface eucjp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

>>> design/eucjp_out_if.sv
// Output channel interface: one Compound Text byte per item with its flags.
`default_nettype none
interface eucjp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       end_of_text;
    logic       truncated;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_text, output truncated, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_text, input truncated, output ready);
endinterface
`default_nettype wire

>>> design/eucjp_to_compound_text_core.sv
// EUC-JP to Compound Text converter: front end, command queue and byte emitter.
// An accepted byte's result passes through the command queue and then the output register.
// Throughput: one input byte per cycle while the queue has room; a set change adds 3 or 4
// escape bytes; the byte emitter sends one output byte per cycle while ctext is ready.
// Reset (rst_n low, asynchronous) clears the designated set, the trail count,
// the queue and the output register; no clearing pass follows.
`default_nettype none
module eucjp_to_compound_text_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    eucjp_in_if.sink     euc,
    eucjp_out_if.source  ctext
);

    logic            push_valid, push_ready;
    logic            pop_valid, pop_ready;
    eucjp_pkg::cmd_t push_cmd, pop_cmd;

    eucjp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .euc        (euc),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    eucjp_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd),
        .pop_ready  (pop_ready)
    );

    eucjp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop_ready (pop_ready),
        .ctext     (ctext)
    );

endmodule
`default_nettype wire

>>> design/eucjp_front.sv
// Front end: accepts EUC-JP bytes, tracks the designated set and trail count, issues commands.
`default_nettype none
module eucjp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    eucjp_in_if.sink           euc,
    output logic               push_valid,
    output eucjp_pkg::cmd_t    push_cmd,
    input  wire logic          push_ready
);

    eucjp_pkg::right_set_t right_set_reg, right_set_next;
    logic [1:0]            trail_left_reg, trail_left_next;
    logic                  has_result;
    logic                  accept;

    assign euc.ready  = push_ready;
    assign accept     = euc.valid && push_ready;
    assign push_valid = accept && has_result;

    always_comb
    begin
        right_set_next    = right_set_reg;
        trail_left_next   = trail_left_reg;
        has_result        = 1'b1;
        push_cmd.esc_sel  = eucjp_pkg::SET_NONE;
        push_cmd.has_byte = 1'b1;
        push_cmd.data     = euc.in_byte;
        push_cmd.eot      = 1'b0;
        push_cmd.trunc    = 1'b0;
        priority if (euc.in_byte == eucjp_pkg::BYTE_NUL)
        begin
            push_cmd.eot    = 1'b1;
            push_cmd.trunc  = (trail_left_reg != 2'd0);
            right_set_next  = eucjp_pkg::SET_NONE;
            trail_left_next = 2'd0;
        end
        else if (trail_left_reg != 2'd0)
        begin
            trail_left_next = trail_left_reg - 2'd1;
        end
        else if (euc.in_byte <= eucjp_pkg::ASCII_MAX)
        begin
            has_result = 1'b1;
        end
        else if (euc.in_byte == eucjp_pkg::BYTE_SS2)
        begin
            // The shift byte itself is dropped; only a set change produces output.
            push_cmd.has_byte = 1'b0;
            has_result        = (right_set_reg != eucjp_pkg::SET_JX0201);
            push_cmd.esc_sel  = has_result ? eucjp_pkg::SET_JX0201 : eucjp_pkg::SET_NONE;
            right_set_next    = eucjp_pkg::SET_JX0201;
            trail_left_next   = 2'd1;
        end
        else if (euc.in_byte == eucjp_pkg::BYTE_SS3)
        begin
            push_cmd.has_byte = 1'b0;
            has_result        = (right_set_reg != eucjp_pkg::SET_JX0212);
            push_cmd.esc_sel  = has_result ? eucjp_pkg::SET_JX0212 : eucjp_pkg::SET_NONE;
            right_set_next    = eucjp_pkg::SET_JX0212;
            trail_left_next   = 2'd2;
        end
        else
        begin
            push_cmd.esc_sel = (right_set_reg != eucjp_pkg::SET_JX0208)
                             ? eucjp_pkg::SET_JX0208 : eucjp_pkg::SET_NONE;
            right_set_next   = eucjp_pkg::SET_JX0208;
            trail_left_next  = 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_set_reg  <= eucjp_pkg::SET_NONE;
            trail_left_reg <= 2'd0;
        end
        else if (accept)
        begin
            right_set_reg  <= right_set_next;
            trail_left_reg <= trail_left_next;
        end
    end

endmodule
`default_nettype wire

>>> design/eucjp_cmdq.sv
// Short command queue between the front end and the byte emitter.
`default_nettype none
module eucjp_cmdq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    input  eucjp_pkg::cmd_t    push_cmd,
    output logic               push_ready,
    output logic               pop_valid,
    output eucjp_pkg::cmd_t    pop_cmd,
    input  wire logic          pop_ready
);

    eucjp_pkg::cmd_t                mem_reg [eucjp_pkg::QDEPTH];
    logic [eucjp_pkg::QPTR_W-1:0]   head_reg, head_next;
    logic [eucjp_pkg::QPTR_W-1:0]   tail_reg, tail_next;
    logic [eucjp_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                           do_push, do_pop;

    assign push_ready = (count_reg != eucjp_pkg::QCNT_W'(eucjp_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[head_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = do_pop  ? head_reg + eucjp_pkg::QPTR_W'(1) : head_reg;
        tail_next  = do_push ? tail_reg + eucjp_pkg::QPTR_W'(1) : tail_reg;
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + eucjp_pkg::QCNT_W'(1);
            2'b01:   count_next = count_reg - eucjp_pkg::QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[tail_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

>>> design/eucjp_back.sv
// Back end: sends each command's escape bytes and optional byte, one per cycle while ready.
`default_nettype none
module eucjp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    input  eucjp_pkg::cmd_t    pop_cmd,
    output logic               pop_ready,
    eucjp_out_if.source        ctext
);

    logic [2:0] pos_reg, pos_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       eot_reg, eot_next;
    logic       trunc_reg, trunc_next;
    logic       advance;
    logic [2:0] elen;
    logic [2:0] total;
    logic       at_last;

    assign advance = !valid_reg || ctext.ready;
    assign elen    = eucjp_pkg::esc_len(pop_cmd.esc_sel);
    assign total   = elen + {2'b00, pop_cmd.has_byte};
    assign at_last = (pos_reg == total - 3'd1);
    // The queue entry is released together with its final byte.
    assign pop_ready = advance && at_last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        eot_next   = eot_reg;
        trunc_next = trunc_reg;
        if (advance)
        begin
            valid_next = pop_valid;
            if (pop_valid)
            begin
                byte_next  = (pos_reg < elen) ? eucjp_pkg::esc_byte(pop_cmd.esc_sel, pos_reg[1:0])
                                              : pop_cmd.data;
                last_next  = at_last;
                eot_next   = pop_cmd.eot && at_last;
                trunc_next = pop_cmd.trunc && at_last;
                pos_next   = at_last ? 3'd0 : pos_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        eot_reg   <= eot_next;
        trunc_reg <= trunc_next;
    end

    assign ctext.valid       = valid_reg;
    assign ctext.out_byte    = byte_reg;
    assign ctext.last_of_run = last_reg;
    assign ctext.end_of_text = eot_reg;
    assign ctext.truncated   = trunc_reg;

endmodule
`default_nettype wire

>>> design/eucjp_checker.sv
// Port-level checker for the converter and its bind to the top level.
`default_nettype none
module eucjp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       last_of_run,
    input wire logic       end_of_text,
    input wire logic       truncated
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_byte_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte))
        else $error("output byte changed while stalled");

    // The terminator is always the only and final byte of its run.
    a_eot_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> last_of_run && (out_byte == 8'h00))
        else $error("terminator not a final zero byte");

    // Escape and trail bytes are never zero, so a zero byte must be the terminator.
    a_zero_is_eot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_byte == 8'h00) |-> end_of_text)
        else $error("zero byte without end of text");

    a_trunc_on_eot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && truncated |-> end_of_text)
        else $error("truncated flag outside terminator");

endmodule

bind eucjp_to_compound_text_core eucjp_checker u_eucjp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (ctext.valid),
    .out_ready   (ctext.ready),
    .out_byte    (ctext.out_byte),
    .last_of_run (ctext.last_of_run),
    .end_of_text (ctext.end_of_text),
    .truncated   (ctext.truncated)
);
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for the EUC-JP to Compound Text converter core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] ESC_BYTE = 8'h1b;

    typedef struct {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_text;
        logic       truncated;
    } ctext_beat_t;

    logic clk;
    logic rst_n;

    eucjp_in_if  euc_if ();
    eucjp_out_if ctext_if ();

    eucjp_to_compound_text_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .euc   (euc_if),
        .ctext (ctext_if)
    );

    // Predictor state: designated right-half set and pending trail bytes.
    eucjp_pkg::right_set_t cur_set;
    logic [1:0]            trail_count;
    ctext_beat_t           expected_ctext[$];

    int  error_count;
    int  bytes_sent;
    bit  tx_steady;
    bit  rx_steady;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    function automatic void push_ctext(input logic [7:0] b, input logic eot, input logic trunc);
        ctext_beat_t beat;
        beat.out_byte    = b;
        beat.last_of_run = 1'b0;
        beat.end_of_text = eot;
        beat.truncated   = trunc;
        expected_ctext.push_back(beat);
    endfunction

    // Works out the Compound Text bytes that one accepted EUC-JP byte produces.
    function automatic void convert_byte(input logic [7:0] b);
        int                    start;
        eucjp_pkg::right_set_t want;
        logic [7:0]            esc[$];
        start = expected_ctext.size();
        if (b == eucjp_pkg::BYTE_NUL)
        begin
            push_ctext(eucjp_pkg::BYTE_NUL, 1'b1, trail_count != 2'd0);
            cur_set     = eucjp_pkg::SET_NONE;
            trail_count = 2'd0;
        end
        else if (trail_count != 2'd0)
        begin
            push_ctext(b, 1'b0, 1'b0);
            trail_count = trail_count - 2'd1;
        end
        else if (b <= eucjp_pkg::ASCII_MAX)
        begin
            push_ctext(b, 1'b0, 1'b0);
        end
        else
        begin
            if (b == eucjp_pkg::BYTE_SS2)
                want = eucjp_pkg::SET_JX0201;
            else if (b == eucjp_pkg::BYTE_SS3)
                want = eucjp_pkg::SET_JX0212;
            else
                want = eucjp_pkg::SET_JX0208;
            if (want != cur_set)
            begin
                case (want)
                    eucjp_pkg::SET_JX0201: esc = '{ESC_BYTE, 8'h29, 8'h49};
                    eucjp_pkg::SET_JX0208: esc = '{ESC_BYTE, 8'h24, 8'h29, 8'h42};
                    default:               esc = '{ESC_BYTE, 8'h24, 8'h29, 8'h44};
                endcase
                foreach (esc[i])
                    push_ctext(esc[i], 1'b0, 1'b0);
                cur_set = want;
            end
            // The lead byte of a two-byte character is kept; shift bytes are dropped.
            if (want == eucjp_pkg::SET_JX0208)
                push_ctext(b, 1'b0, 1'b0);
            trail_count = (want == eucjp_pkg::SET_JX0212) ? 2'd2 : 2'd1;
        end
        if (expected_ctext.size() > start)
            expected_ctext[expected_ctext.size() - 1].last_of_run = 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            euc_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        euc_if.valid   <= 1'b1;
        euc_if.in_byte <= b;
        do
            @(posedge clk);
        while (!euc_if.ready);
        convert_byte(b);
        bytes_sent++;
    endtask

    task automatic send_sequence(input logic [7:0] seq[]);
        foreach (seq[i])
            send_byte(seq[i]);
    endtask

    // Holds the input idle until every predicted byte has come out.
    task automatic wait_for_ctext_drained();
        @(negedge clk);
        euc_if.valid <= 1'b0;
        while (expected_ctext.size() != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls before each item, ready held until it is taken.
    initial
    begin
        int gap;
        ctext_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = rx_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                ctext_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            ctext_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!ctext_if.valid);
        end
    end

    always @(posedge clk)
    begin
        ctext_beat_t want;
        if (rst_n && ctext_if.valid && ctext_if.ready)
        begin
            if (expected_ctext.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output byte %02h", ctext_if.out_byte));
            end
            else
            begin
                want = expected_ctext.pop_front();
                if (ctext_if.out_byte !== want.out_byte)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              ctext_if.out_byte, want.out_byte));
                if (ctext_if.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                              ctext_if.last_of_run, want.last_of_run,
                                              want.out_byte));
                if (ctext_if.end_of_text !== want.end_of_text)
                    report_mismatch($sformatf("end_of_text %b, expected %b on byte %02h",
                                              ctext_if.end_of_text, want.end_of_text,
                                              want.out_byte));
                if (ctext_if.truncated !== want.truncated)
                    report_mismatch($sformatf("truncated %b, expected %b on byte %02h",
                                              ctext_if.truncated, want.truncated,
                                              want.out_byte));
            end
        end
    end

    task automatic test_ascii_passthrough();
        send_sequence('{8'h01, 8'h7f, 8'h55, 8'h2a});
    endtask

    // The second single shift finds the kana set already designated: no output at all.
    task automatic test_kana_single_shift();
        send_sequence('{eucjp_pkg::BYTE_SS2, 8'ha6, eucjp_pkg::BYTE_SS2, 8'hdf});
    endtask

    task automatic test_jisx0208();
        send_sequence('{8'hb0, 8'ha1, 8'hff, 8'hfe});
    endtask

    // After the three-byte character the set stays put, so the next SS3 only
    // expects trail bytes; ASCII and SS2 values then pass as plain trail bytes.
    task automatic test_jisx0212_and_odd_trails();
        send_sequence('{eucjp_pkg::BYTE_SS3, 8'hb0, 8'ha1, eucjp_pkg::BYTE_SS3, 8'h41,
                        eucjp_pkg::BYTE_SS2});
    endtask

    task automatic test_terminator();
        send_sequence('{eucjp_pkg::BYTE_NUL, eucjp_pkg::BYTE_SS3, eucjp_pkg::BYTE_NUL,
                        8'hb1, eucjp_pkg::BYTE_NUL, eucjp_pkg::BYTE_SS2, 8'h30});
    endtask

    task automatic test_random_text(input int target);
        int         pick;
        logic [7:0] lead;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                tx_steady = $urandom_range(0, 2) == 0;
                rx_steady = $urandom_range(0, 2) == 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_byte(8'($urandom_range(1, 127)));
            end
            else if (pick < 60)
            begin
                lead = 8'($urandom_range(128, 255));
                if (lead == eucjp_pkg::BYTE_SS2 || lead == eucjp_pkg::BYTE_SS3)
                    lead = 8'hb0;
                send_byte(lead);
                send_byte(8'($urandom_range(128, 255)));
            end
            else if (pick < 72)
            begin
                send_byte(eucjp_pkg::BYTE_SS2);
                send_byte(8'($urandom_range(8'ha1, 8'hdf)));
            end
            else if (pick < 82)
            begin
                send_byte(eucjp_pkg::BYTE_SS3);
                send_byte(8'($urandom_range(128, 255)));
                send_byte(8'($urandom_range(128, 255)));
            end
            else if (pick < 88)
            begin
                send_byte(eucjp_pkg::BYTE_NUL);
            end
            else
            begin
                // Noise: any byte, which can cut a character short or start one oddly.
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        euc_if.valid   = 1'b0;
        euc_if.in_byte = 8'h00;
        cur_set        = eucjp_pkg::SET_NONE;
        trail_count    = 2'd0;
        error_count    = 0;
        bytes_sent     = 0;
        tx_steady      = 1'b0;
        rx_steady      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ascii_passthrough();
        test_kana_single_shift();
        test_jisx0208();
        test_jisx0212_and_odd_trails();
        test_terminator();
        wait_for_ctext_drained();
        test_random_text(bytes_sent + 218);
        wait_for_ctext_drained();
        test_random_text(bytes_sent + 218);
        wait_for_ctext_drained();
        repeat (8) @(posedge clk);

        if (error_count == 0 && expected_ctext.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout with %0d bytes still expected", expected_ctext.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
